[rtl/frustum_cull_test_defines.svh]
// assertion macros shared by the culling block
`ifndef FRUSTUM_CULL_TEST_DEFINES_SVH
`define FRUSTUM_CULL_TEST_DEFINES_SVH

// property that must hold at every edge out of reset
`define FCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fct_pkg.sv]
`timescale 1ns / 1ps
package fct_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int PLANE_W     = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int IDX_W       = 3;
  localparam int NRM_W       = 18;
  localparam int CRD_W       = 32;
  localparam int EXT_W       = 31;
  localparam int FRAC_W      = 16;
  // doubled cube corner coordinate: 2*c +/- extent
  localparam int OPND_W      = 34;
  localparam int PROD_W      = NRM_W + OPND_W;
  localparam int ACC_W       = PROD_W + 4;

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_SPHERE = 2'd1,
    FUNC_CUBE   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_SUM,
    ST_DONE
  } state_e;

  // multiply-accumulate controls from the sequencer
  typedef struct packed {
    logic init;
    logic mul;
    logic acc;
  } mac_ctl_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic signed [CRD_W-1:0] d;
  } plane_t;

endpackage

[rtl/fct_mac.sv]
`timescale 1ns / 1ps
module fct_mac import fct_pkg::*; (
  input  logic                    clk_i,
  input  mac_ctl_t                ctl_i,
  input  logic signed [ACC_W-1:0] init_i,
  input  logic signed [NRM_W-1:0] coef_i,
  input  logic signed [OPND_W-1:0] opnd_i,
  output logic signed [ACC_W-1:0] sum_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  // running sum plus the product in flight
  assign sum_o = acc_q + ACC_W'(prod_q);

  // one multiply per cycle while ctl_i.mul is set, registered before the add
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      prod_q <= PROD_W'(coef_i) * PROD_W'(opnd_i);
    end
    if (ctl_i.init) begin
      acc_q <= init_i;
    end else if (ctl_i.acc) begin
      acc_q <= sum_o;
    end
  end

endmodule

[rtl/frustum_cull_test.sv]
`timescale 1ns / 1ps
// frustum_cull_test: sphere and axis-aligned cube culling against stored planes
// Input channel (in_valid_i/in_ready_o) carries one item: func_i selects a
// plane write (slot plane_index_i gets normal_*_i and plane_offset_i), a sphere
// test or a cube test (center_*_i, extent_i). Every item returns exactly one
// result item on the output channel (out_valid_o/out_ready_i): visible_o and
// was_test_o, which is 0 for write acknowledges and unused func codes.
// Timing: one shared 18x34 multiplier handles one axis per cycle, so each
// plane goes through ST_MUL_X, ST_MUL_Y, ST_MUL_Z (three products) and
// ST_SUM (the final add and sign check). A test ends early when a plane
// culls it; a write goes straight to ST_DONE. The sequencer is idle again
// as soon as the result is registered, ready for the next item.
// in_ready_o is high only while the sequencer is idle; one item is in work
// at a time. A finished result waits in the output register: when the
// receiver stalls, the sequencer holds its result until the register frees,
// and the next item may be accepted while a result still waits to be taken.
// Reset clears all planes to zero (spheres visible, cubes culled) and
// empties the output register.
`include "frustum_cull_test_defines.svh"
module frustum_cull_test import fct_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              func_i,
  input  logic [IDX_W-1:0]        plane_index_i,
  input  logic signed [NRM_W-1:0] normal_x_i,
  input  logic signed [NRM_W-1:0] normal_y_i,
  input  logic signed [NRM_W-1:0] normal_z_i,
  input  logic signed [CRD_W-1:0] plane_offset_i,
  input  logic signed [CRD_W-1:0] center_x_i,
  input  logic signed [CRD_W-1:0] center_y_i,
  input  logic signed [CRD_W-1:0] center_z_i,
  input  logic [EXT_W-1:0]        extent_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    visible_o,
  output logic                    was_test_o
);

  state_e                  state_q, state_d;
  logic [PLANE_W-1:0]      plane_q;
  plane_t                  planes_q [PLANE_COUNT];
  func_e                   func_q;
  logic signed [CRD_W-1:0] cx_q, cy_q, cz_q;
  logic [EXT_W-1:0]        ext_q;
  logic                    vis_q, test_q;
  logic                    out_valid_q, out_vis_q, out_test_q;

  logic                    in_acc;
  logic                    out_free;
  logic                    wr_en;
  plane_t                  cur;
  mac_ctl_t                ctl;
  logic signed [NRM_W-1:0] coef;
  logic signed [CRD_W-1:0] crd;
  logic signed [OPND_W-1:0] crd_s, ext_s, opnd;
  logic signed [ACC_W-1:0] init_val, d_s, ext_a, sum;
  logic                    fail;
  logic                    last_plane;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign visible_o   = out_vis_q;
  assign was_test_o  = out_test_q;

  assign wr_en = in_acc && (func_e'(func_i) == FUNC_WRITE)
                 && ({1'b0, plane_index_i} < (IDX_W + 1)'(PLANE_COUNT));

  // plane slots, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        planes_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        if (wr_en && plane_index_i == IDX_W'(i)) begin
          planes_q[i] <= '{nx: normal_x_i, ny: normal_y_i, nz: normal_z_i,
                           d: plane_offset_i};
        end
      end
    end
  end

  assign cur = planes_q[plane_q];

  // per-axis operand select
  always_comb begin
    case (state_q)
      ST_MUL_Y: begin
        coef = cur.ny;
        crd  = cy_q;
      end
      ST_MUL_Z: begin
        coef = cur.nz;
        crd  = cz_q;
      end
      default: begin
        coef = cur.nx;
        crd  = cx_q;
      end
    endcase
  end

  // cube takes the corner that maximizes the distance on this axis
  assign crd_s = OPND_W'(crd);
  assign ext_s = {{(OPND_W - EXT_W){1'b0}}, ext_q};
  assign opnd  = (func_q == FUNC_CUBE)
                 ? ((crd_s <<< 1) + (coef[NRM_W-1] ? -ext_s : ext_s))
                 : crd_s;

  // starting sum: offset (plus radius for spheres) at product scale
  assign d_s      = ACC_W'(cur.d);
  assign ext_a    = {{(ACC_W - EXT_W){1'b0}}, ext_q};
  assign init_val = (func_q == FUNC_CUBE) ? (d_s <<< (FRAC_W + 1))
                                          : ((d_s + ext_a) <<< FRAC_W);

  fct_mac u_mac (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .init_i (init_val),
    .coef_i (coef),
    .opnd_i (opnd),
    .sum_o  (sum)
  );

  // sphere culls on a negative margin, cube when no corner is strictly inside
  assign fail = (func_q == FUNC_CUBE) ? (sum[ACC_W-1] || (sum == '0)) : sum[ACC_W-1];
  assign last_plane = (plane_q == PLANE_W'(PLANE_COUNT - 1));

  // sequencer next state and unit controls
  always_comb begin
    state_d  = state_q;
    ctl      = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (func_e'(func_i) == FUNC_SPHERE || func_e'(func_i) == FUNC_CUBE) begin
            state_d = ST_MUL_X;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MUL_X: begin
        ctl.init = 1'b1;
        ctl.mul  = 1'b1;
        state_d  = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        ctl.mul = 1'b1;
        ctl.acc = 1'b1;
        state_d = ST_MUL_Z;
      end
      ST_MUL_Z: begin
        ctl.mul = 1'b1;
        ctl.acc = 1'b1;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        if (fail || last_plane) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_MUL_X;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      plane_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        plane_q <= '0;
      end else if (state_q == ST_SUM && !fail && !last_plane) begin
        plane_q <= plane_q + PLANE_W'(1);
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item payload and result registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_e'(func_i);
      cx_q   <= center_x_i;
      cy_q   <= center_y_i;
      cz_q   <= center_z_i;
      ext_q  <= extent_i;
      vis_q  <= 1'b0;
      test_q <= (func_e'(func_i) == FUNC_SPHERE) || (func_e'(func_i) == FUNC_CUBE);
    end else if (state_q == ST_SUM) begin
      if (fail) begin
        vis_q <= 1'b0;
      end else if (last_plane) begin
        vis_q <= 1'b1;
      end
    end
    if (state_q == ST_DONE && out_free) begin
      out_vis_q  <= vis_q;
      out_test_q <= test_q;
    end
  end

  // checks
  `FCT_ASSERT(a_ack_not_visible, !(out_valid_o && !was_test_o && visible_o),
              "write acknowledge reported visible")
  `FCT_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready_o,
                   "ready stayed high after an accepted item")
  `FCT_ASSERT(a_plane_in_range, {1'b0, plane_q} < (PLANE_W + 1)'(PLANE_COUNT),
              "plane counter beyond last plane")
  `FCT_ASSERT_NEXT(a_result_from_done, !out_valid_q && state_q != ST_DONE, !out_valid_q,
                   "result appeared without a finished item")

endmodule

[tb/tb_frustum_cull_test.sv]
`timescale 1ns / 1ps
module tb_frustum_cull_test;
  import fct_pkg::*;

  localparam longint ONE_Q16     = 64'sd65536;
  localparam longint TWO_Q16     = 64'sd131072;
  localparam int     ONE         = 1 << FRAC_W;
  localparam int     BOX_HALF    = 10 << FRAC_W;
  localparam int     LONG_HOLD   = 400;
  localparam int     CYCLE_LIMIT = 400000;

  typedef struct {
    func_e                   func;
    logic [IDX_W-1:0]        idx;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic signed [CRD_W-1:0] off;
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
    logic signed [CRD_W-1:0] cz;
    logic [EXT_W-1:0]        ext;
  } cull_item_t;

  typedef struct packed {
    logic visible;
    logic was_test;
  } verdict_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              func_i = '0;
  logic [IDX_W-1:0]        plane_index_i = '0;
  logic signed [NRM_W-1:0] normal_x_i = '0;
  logic signed [NRM_W-1:0] normal_y_i = '0;
  logic signed [NRM_W-1:0] normal_z_i = '0;
  logic signed [CRD_W-1:0] plane_offset_i = '0;
  logic signed [CRD_W-1:0] center_x_i = '0;
  logic signed [CRD_W-1:0] center_y_i = '0;
  logic signed [CRD_W-1:0] center_z_i = '0;
  logic [EXT_W-1:0]        extent_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    visible_o;
  logic                    was_test_o;

  // shadow copy of the plane store and results still owed by the block
  plane_t   shadow_planes [PLANE_COUNT];
  verdict_t pending_verdicts [$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  bit       steady_feed = 1'b0;
  bit       long_hold_req = 1'b0;

  frustum_cull_test DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .plane_index_i (plane_index_i),
    .normal_x_i    (normal_x_i),
    .normal_y_i    (normal_y_i),
    .normal_z_i    (normal_z_i),
    .plane_offset_i(plane_offset_i),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .center_z_i    (center_z_i),
    .extent_i      (extent_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .visible_o     (visible_o),
    .was_test_o    (was_test_o)
  );

  always #4 clk_i = ~clk_i;

  // sphere survives when no plane puts its center below minus the radius
  function automatic logic sphere_in_view(cull_item_t it);
    longint sdist;
    longint floor_dist;
    logic   seen;
    seen = 1'b1;
    floor_dist = -(longint'(it.ext) * ONE_Q16);
    for (int i = 0; i < PLANE_COUNT; i++) begin
      sdist = longint'($signed(shadow_planes[i].nx)) * longint'(it.cx)
            + longint'($signed(shadow_planes[i].ny)) * longint'(it.cy)
            + longint'($signed(shadow_planes[i].nz)) * longint'(it.cz)
            + longint'($signed(shadow_planes[i].d)) * ONE_Q16;
      if (sdist < floor_dist) seen = 1'b0;
    end
    return seen;
  endfunction

  // cube survives when each plane has a corner strictly in front, doubled coords
  function automatic logic cube_in_view(cull_item_t it);
    longint x2 [2];
    longint y2 [2];
    longint z2 [2];
    longint nx, ny, nz, dd, sdist;
    logic   seen, lit;
    x2[0] = 2 * longint'(it.cx) - longint'(it.ext);
    x2[1] = 2 * longint'(it.cx) + longint'(it.ext);
    y2[0] = 2 * longint'(it.cy) - longint'(it.ext);
    y2[1] = 2 * longint'(it.cy) + longint'(it.ext);
    z2[0] = 2 * longint'(it.cz) - longint'(it.ext);
    z2[1] = 2 * longint'(it.cz) + longint'(it.ext);
    seen = 1'b1;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      nx = longint'($signed(shadow_planes[i].nx));
      ny = longint'($signed(shadow_planes[i].ny));
      nz = longint'($signed(shadow_planes[i].nz));
      dd = longint'($signed(shadow_planes[i].d));
      lit = 1'b0;
      for (int k = 0; k < 8; k++) begin
        sdist = nx * x2[k & 1] + ny * y2[(k >> 1) & 1] + nz * z2[(k >> 2) & 1]
              + dd * TWO_Q16;
        if (sdist > 0) lit = 1'b1;
      end
      if (!lit) seen = 1'b0;
    end
    return seen;
  endfunction

  // apply an accepted item to the shadow planes and queue its verdict
  function automatic void record_item(cull_item_t it);
    verdict_t v;
    v = '{visible: 1'b0, was_test: 1'b0};
    case (it.func)
      FUNC_WRITE: begin
        if (it.idx < PLANE_COUNT)
          shadow_planes[it.idx] = '{nx: it.nx, ny: it.ny, nz: it.nz, d: it.off};
      end
      FUNC_SPHERE: v = '{visible: sphere_in_view(it), was_test: 1'b1};
      FUNC_CUBE:   v = '{visible: cube_in_view(it), was_test: 1'b1};
      default: ;
    endcase
    pending_verdicts.push_back(v);
  endfunction

  // item builders; fields the operation ignores carry random junk
  function automatic cull_item_t random_item();
    cull_item_t it;
    it.func = func_e'($urandom_range(0, 3));
    it.idx  = IDX_W'($urandom_range(0, 7));
    it.nx   = NRM_W'($urandom());
    it.ny   = NRM_W'($urandom());
    it.nz   = NRM_W'($urandom());
    it.off  = $urandom();
    it.cx   = $urandom();
    it.cy   = $urandom();
    it.cz   = $urandom();
    it.ext  = EXT_W'($urandom());
    return it;
  endfunction

  function automatic cull_item_t plane_write(int idx, int nx, int ny, int nz, int off);
    cull_item_t it;
    it      = random_item();
    it.func = FUNC_WRITE;
    it.idx  = IDX_W'(idx);
    it.nx   = NRM_W'(nx);
    it.ny   = NRM_W'(ny);
    it.nz   = NRM_W'(nz);
    it.off  = off;
    return it;
  endfunction

  function automatic cull_item_t volume_test(func_e f, int cx, int cy, int cz, int ext);
    cull_item_t it;
    it      = random_item();
    it.func = f;
    it.cx   = cx;
    it.cy   = cy;
    it.cz   = cz;
    it.ext  = EXT_W'(ext);
    return it;
  endfunction

  function automatic int spread(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic cull_item_t random_volume();
    func_e f;
    f = $urandom_range(0, 1) ? FUNC_SPHERE : FUNC_CUBE;
    return volume_test(f, spread(1 << 22), spread(1 << 22), spread(1 << 22),
                       int'($urandom_range(0, 1 << 21)));
  endfunction

  // offer one item, idling between bursts, and wait for the handshake
  task automatic send_item(cull_item_t it);
    if (!steady_feed && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i     <= 1'b1;
    func_i         <= it.func;
    plane_index_i  <= it.idx;
    normal_x_i     <= it.nx;
    normal_y_i     <= it.ny;
    normal_z_i     <= it.nz;
    plane_offset_i <= it.off;
    center_x_i     <= it.cx;
    center_y_i     <= it.cy;
    center_z_i     <= it.cz;
    extent_i       <= it.ext;
    do @(posedge clk_i); while (!in_ready_o);
    record_item(it);
  endtask

  task automatic write_random_frustum();
    for (int i = 0; i < PLANE_COUNT; i++)
      send_item(plane_write(i, spread(ONE), spread(ONE), spread(ONE),
                            int'($urandom_range(1 << 20, 1 << 23))));
  endtask

  // all-zero planes: sphere passes, cube fails; unused func answers zeros
  task automatic test_reset_planes();
    send_item(volume_test(FUNC_SPHERE, spread(1 << 24), spread(1 << 24), spread(1 << 24),
                          int'($urandom_range(0, 1 << 20))));
    send_item(volume_test(FUNC_CUBE, spread(1 << 24), spread(1 << 24), spread(1 << 24),
                          int'($urandom_range(1, 1 << 20))));
    send_item(volume_test(FUNC_NONE, 0, 0, 0, 0));
  endtask

  // writes past the last plane slot are acknowledged and dropped
  task automatic test_ignored_writes();
    send_item(plane_write(6, -ONE, ONE, ONE, -BOX_HALF));
    send_item(plane_write(7, ONE, -ONE, -ONE, -BOX_HALF));
    send_item(volume_test(FUNC_SPHERE, 0, 0, 0, 0));
    send_item(volume_test(FUNC_CUBE, 0, 0, 0, ONE));
  endtask

  // axis box frustum, then volumes exactly on and just past the near plane
  task automatic test_plane_boundaries();
    send_item(plane_write(0, ONE, 0, 0, BOX_HALF));
    send_item(plane_write(1, -ONE, 0, 0, BOX_HALF));
    send_item(plane_write(2, 0, ONE, 0, BOX_HALF));
    send_item(plane_write(3, 0, -ONE, 0, BOX_HALF));
    send_item(plane_write(4, 0, 0, ONE, BOX_HALF));
    send_item(plane_write(5, 0, 0, -ONE, BOX_HALF));
    // sphere touching at minus the radius still counts, one lsb further is culled
    send_item(volume_test(FUNC_SPHERE, -BOX_HALF - 3 * ONE, 0, 0, 3 * ONE));
    send_item(volume_test(FUNC_SPHERE, -BOX_HALF - 3 * ONE - 1, 0, 0, 3 * ONE));
    // cube with its best corner exactly on the plane is culled
    send_item(volume_test(FUNC_CUBE, -BOX_HALF - 2 * ONE, 0, 0, 4 * ONE));
    send_item(volume_test(FUNC_CUBE, -BOX_HALF - 2 * ONE + 1, 0, 0, 4 * ONE));
    // odd edge length, half an lsb
    send_item(volume_test(FUNC_CUBE, -BOX_HALF, 0, 0, 1));
  endtask

  // extreme normals, offsets, centers and extents
  task automatic test_field_extremes();
    send_item(plane_write(0, -131072, 131071, -131072, 32'sh8000_0000));
    send_item(volume_test(FUNC_SPHERE, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                          32'h7fff_ffff));
    send_item(volume_test(FUNC_CUBE, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                          32'h7fff_ffff));
    send_item(plane_write(5, 131071, -131072, 131071, 32'sh7fff_ffff));
    send_item(volume_test(FUNC_SPHERE, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 0));
    send_item(volume_test(FUNC_CUBE, 0, 0, 0, 0));
  endtask

  // mostly coherent frustum-and-volume traffic with some noise
  task automatic test_random_traffic(int count);
    int         pick;
    cull_item_t it;
    for (int i = 0; i < count; i++) begin
      if (i % 120 == 0) write_random_frustum();
      if (i % 150 == 75) steady_feed = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 6)
        it = plane_write($urandom_range(0, 7), spread(ONE), spread(ONE), spread(ONE),
                         int'($urandom_range(1 << 20, 1 << 23)));
      else if (pick < 10)
        it = random_item();
      else if (pick < 13)
        it = volume_test(FUNC_NONE, spread(1 << 22), 0, 0, 0);
      else if (pick < 88)
        it = random_volume();
      else begin
        it      = random_item();
        it.func = $urandom_range(0, 1) ? FUNC_SPHERE : FUNC_CUBE;
      end
      send_item(it);
    end
    steady_feed = 1'b0;
  endtask

  // receiver holds off while items keep coming, so the input stalls
  task automatic test_output_stall();
    steady_feed   = 1'b1;
    long_hold_req = 1'b1;
    for (int i = 0; i < 24; i++) send_item(random_volume());
    steady_feed = 1'b0;
  endtask

  // receiver ready pattern, plus the long hold-off on request
  initial begin : receiver
    int pattern;
    int phase;
    pattern = 0;
    phase = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else begin
        if (phase == 0) begin
          pattern = $urandom_range(0, 3);
          phase   = $urandom_range(8, 80);
        end
        phase--;
        case (pattern)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= phase[2];
        endcase
      end
    end
  end

  // compare each taken result with the oldest verdict owed
  always @(posedge clk_i) begin : check_results
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result: visible %0b was_test %0b",
                 $time, visible_o, was_test_o);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (visible_o !== want.visible) begin
          $display("%0t: visible mismatch: expected %0b actual %0b",
                   $time, want.visible, visible_o);
          mismatch_count++;
        end
        if (was_test_o !== want.was_test) begin
          $display("%0t: was_test mismatch: expected %0b actual %0b",
                   $time, want.was_test, was_test_o);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < PLANE_COUNT; i++) shadow_planes[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_planes();
    test_ignored_writes();
    test_plane_boundaries();
    test_field_extremes();
    test_random_traffic(350);
    test_output_stall();
    test_random_traffic(340);
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
